// ===== design/kvls_pkg.sv =====
// Package for the key/value line splitter: byte codes, comment-scan phases and field widths.
// No dependencies. Used by kvls_region_fmt and key_value_line_splitter_top.
package kvls_pkg;

	localparam int unsigned FIELD_W  = 16;
	localparam int unsigned LINE_N_W = 32;
	localparam int unsigned NUM_REG  = 3;

	localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

	// Text regions tracked per line.
	localparam int unsigned RG_LINE  = 0;
	localparam int unsigned RG_KEY   = 1;
	localparam int unsigned RG_VALUE = 2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// Comment detection phase of the current line.
	typedef enum logic [3:0] {
		PH_AWAIT   = 4'b0001,
		PH_SLASH   = 4'b0010,
		PH_COMMENT = 4'b0100,
		PH_CONTENT = 4'b1000
	} phase_t;

endpackage

// ===== design/kvls_region_fmt.sv =====
// Turns the tracked bounds of one text region into a clamped start and length.
// Depends on kvls_pkg.
module kvls_region_fmt
	import kvls_pkg::*;
#(
	parameter int unsigned OFFSET_WIDTH = 16
) (
	input  logic                    nb_valid,
	input  logic [OFFSET_WIDTH-1:0] first_nb,
	input  logic [OFFSET_WIDTH-1:0] last_nb,
	input  logic [OFFSET_WIDTH-1:0] region_end,
	output logic [FIELD_W-1:0]      start,
	output logic [FIELD_W-1:0]      length
);

	logic [OFFSET_WIDTH:0] span;
	logic [32:0]           start_ext;
	logic [32:0]           span_ext;

	assign span      = {1'b0, last_nb} - {1'b0, first_nb} + (OFFSET_WIDTH+1)'(1);
	assign start_ext = nb_valid ? 33'(first_nb) : 33'(region_end);
	assign span_ext  = 33'(span);

	always_comb begin
		if (start_ext > 33'(FIELD_MAX)) begin
			start = FIELD_MAX;
		end else begin
			start = start_ext[FIELD_W-1:0];
		end
		if (!nb_valid) begin
			length = '0;
		end else if (span_ext > 33'(FIELD_MAX)) begin
			length = FIELD_MAX;
		end else begin
			length = span_ext[FIELD_W-1:0];
		end
	end

endmodule

// ===== design/key_value_line_splitter_top.sv =====
// Key/value line splitter top level: byte scan, line state and the record output register.
// Depends on kvls_pkg and kvls_region_fmt.
//
//  channel | signals                                    | payload
//  --------+--------------------------------------------+----------------------------------
//  in      | in_valid / in_stall                        | text_byte, last_byte
//  out     | out_valid / out_stall                      | line_start .. line_number
//  cfg     | cfg_valid / cfg_ready (ready always high)  | raw_line_mode
//
// One byte per cycle unless out_stall holds it: each request sits in one input register,
// the line state and the result register are updated from it, so a record goes from the
// input register to the result register. out_stall holds the result register; the input
// register then holds too and in_stall rises only while it is full. arst_n clears all
// line state and the mode register. After a last byte the line state returns to offset 0.
module key_value_line_splitter_top
	import kvls_pkg::*;
#(
	parameter int unsigned OFFSET_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                raw_line_mode,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          text_byte,
	input  logic                last_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [FIELD_W-1:0]  line_start,
	output logic [FIELD_W-1:0]  line_length,
	output logic                has_key,
	output logic [FIELD_W-1:0]  key_start,
	output logic [FIELD_W-1:0]  key_length,
	output logic [FIELD_W-1:0]  value_start,
	output logic [FIELD_W-1:0]  value_length,
	output logic [LINE_N_W-1:0] line_number
);

	localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

	logic raw_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// line state
	logic [OFFSET_WIDTH-1:0] offset_q;
	logic [LINE_N_W-1:0]     lf_count_q;
	logic                    eq_seen_q;
	logic                    nb_valid_q [NUM_REG];
	logic [OFFSET_WIDTH-1:0] first_q    [NUM_REG];
	logic [OFFSET_WIDTH-1:0] last_q     [NUM_REG];
	logic [OFFSET_WIDTH-1:0] end_q      [NUM_REG];
	phase_t                  phase_q;
	logic                    raw_cut_q;
	logic                    value_cut_q;
	logic                    line_any_q;

	// state after the current byte
	logic [LINE_N_W-1:0]     lf_count_a;
	logic                    eq_seen_a;
	logic                    nb_valid_a [NUM_REG];
	logic [OFFSET_WIDTH-1:0] first_a    [NUM_REG];
	logic [OFFSET_WIDTH-1:0] last_a     [NUM_REG];
	logic [OFFSET_WIDTH-1:0] end_a      [NUM_REG];
	phase_t                  phase_a;
	logic                    raw_cut_a;
	logic                    value_cut_a;
	logic                    line_any_a;

	logic                    advance;
	logic                    fire;
	logic [OFFSET_WIDTH-1:0] pos;
	logic [OFFSET_WIDTH-1:0] pos_inc;
	logic                    is_term;
	logic                    is_blank;
	logic                    emit_term;
	logic                    implied_lf;
	logic                    emit;

	// record source
	logic                    rec_eq;
	logic [LINE_N_W-1:0]     rec_lf;
	logic                    rec_nb    [NUM_REG];
	logic [OFFSET_WIDTH-1:0] rec_first [NUM_REG];
	logic [OFFSET_WIDTH-1:0] rec_last  [NUM_REG];
	logic [OFFSET_WIDTH-1:0] rec_end   [NUM_REG];
	logic [FIELD_W-1:0]      fmt_start [NUM_REG];
	logic [FIELD_W-1:0]      fmt_len   [NUM_REG];

	logic [FIELD_W-1:0]  line_start_q, line_length_q;
	logic                has_key_q;
	logic [FIELD_W-1:0]  key_start_q, key_length_q, value_start_q, value_length_q;
	logic [LINE_N_W-1:0] line_number_q;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			raw_q <= raw_line_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	assign pos      = offset_q;
	assign pos_inc  = (offset_q == OFF_MAX) ? offset_q : offset_q + OFFSET_WIDTH'(1);
	assign is_term  = (byte_s1 == CH_LF) || (byte_s1 == CH_CR) || (byte_s1 == CH_NUL);
	assign is_blank = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);

	always_comb begin
		lf_count_a  = lf_count_q;
		eq_seen_a   = eq_seen_q;
		phase_a     = phase_q;
		raw_cut_a   = raw_cut_q;
		value_cut_a = value_cut_q;
		line_any_a  = line_any_q;
		emit_term   = 1'b0;
		for (int r = 0; r < NUM_REG; r++) begin
			nb_valid_a[r] = nb_valid_q[r];
			first_a[r]    = first_q[r];
			last_a[r]     = last_q[r];
			end_a[r]      = end_q[r];
		end

		if (is_term) begin
			if (byte_s1 == CH_LF) begin
				lf_count_a = lf_count_q + LINE_N_W'(1);
			end
			if (raw_q && (byte_s1 != CH_LF)) begin
				// raw mode: inner CR/NUL only freezes the line and key, and the value once '=' is seen
				raw_cut_a = 1'b1;
				if (eq_seen_q) begin
					value_cut_a = 1'b1;
				end
			end else begin
				emit_term   = raw_q || (line_any_q && (phase_q != PH_COMMENT));
				eq_seen_a   = 1'b0;
				phase_a     = PH_AWAIT;
				raw_cut_a   = 1'b0;
				value_cut_a = 1'b0;
				line_any_a  = 1'b0;
				for (int r = 0; r < NUM_REG; r++) begin
					nb_valid_a[r] = 1'b0;
					first_a[r]    = '0;
					last_a[r]     = '0;
					end_a[r]      = pos_inc;
				end
			end
		end else begin
			line_any_a = 1'b1;
			case (phase_q)
				PH_AWAIT: begin
					if (byte_s1 == CH_HASH) begin
						phase_a = PH_COMMENT;
					end else if (byte_s1 == CH_SLASH) begin
						phase_a = PH_SLASH;
					end else if (!is_blank) begin
						phase_a = PH_CONTENT;
					end
				end
				PH_SLASH: begin
					phase_a = (byte_s1 == CH_SLASH) ? PH_COMMENT : PH_CONTENT;
				end
				default: begin
					phase_a = phase_q;
				end
			endcase

			if (!raw_cut_q) begin
				end_a[RG_LINE] = pos_inc;
				if (!is_blank) begin
					if (!nb_valid_q[RG_LINE]) begin
						nb_valid_a[RG_LINE] = 1'b1;
						first_a[RG_LINE]    = pos;
					end
					last_a[RG_LINE] = pos;
				end
			end

			if ((byte_s1 == CH_EQ) && !eq_seen_q) begin
				eq_seen_a           = 1'b1;
				value_cut_a         = 1'b0;
				nb_valid_a[RG_VALUE] = 1'b0;
				end_a[RG_VALUE]      = pos_inc;
			end else if (!eq_seen_q) begin
				if (!raw_cut_q) begin
					end_a[RG_KEY] = pos_inc;
					if (!is_blank) begin
						if (!nb_valid_q[RG_KEY]) begin
							nb_valid_a[RG_KEY] = 1'b1;
							first_a[RG_KEY]    = pos;
						end
						last_a[RG_KEY] = pos;
					end
				end
			end else if (!value_cut_q) begin
				end_a[RG_VALUE] = pos_inc;
				if (!is_blank) begin
					if (!nb_valid_q[RG_VALUE]) begin
						nb_valid_a[RG_VALUE] = 1'b1;
						first_a[RG_VALUE]    = pos;
					end
					last_a[RG_VALUE] = pos;
				end
			end
		end
	end

	// A last byte other than LF is followed by an implied LF.
	assign implied_lf = last_s1 && (byte_s1 != CH_LF) && !emit_term
		&& (raw_q || (line_any_a && (phase_a != PH_COMMENT)));
	assign emit = emit_term || implied_lf;

	always_comb begin
		if (emit_term) begin
			rec_eq = eq_seen_q;
			rec_lf = lf_count_a;
		end else begin
			rec_eq = eq_seen_a;
			rec_lf = lf_count_a + LINE_N_W'(1);
		end
		for (int r = 0; r < NUM_REG; r++) begin
			rec_nb[r]    = emit_term ? nb_valid_q[r] : nb_valid_a[r];
			rec_first[r] = emit_term ? first_q[r]    : first_a[r];
			rec_last[r]  = emit_term ? last_q[r]     : last_a[r];
			rec_end[r]   = emit_term ? end_q[r]      : end_a[r];
		end
	end

	for (genvar g = 0; g < NUM_REG; g++) begin : g_fmt
		kvls_region_fmt #(
			.OFFSET_WIDTH(OFFSET_WIDTH)
		) u_fmt (
			.nb_valid  (rec_nb[g]),
			.first_nb  (rec_first[g]),
			.last_nb   (rec_last[g]),
			.region_end(rec_end[g]),
			.start     (fmt_start[g]),
			.length    (fmt_len[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			lf_count_q  <= '0;
			eq_seen_q   <= 1'b0;
			phase_q     <= PH_AWAIT;
			raw_cut_q   <= 1'b0;
			value_cut_q <= 1'b0;
			line_any_q  <= 1'b0;
			for (int r = 0; r < NUM_REG; r++) begin
				nb_valid_q[r] <= 1'b0;
				first_q[r]    <= '0;
				last_q[r]     <= '0;
				end_q[r]      <= '0;
			end
		end else if (fire) begin
			if (last_s1) begin
				offset_q    <= '0;
				lf_count_q  <= '0;
				eq_seen_q   <= 1'b0;
				phase_q     <= PH_AWAIT;
				raw_cut_q   <= 1'b0;
				value_cut_q <= 1'b0;
				line_any_q  <= 1'b0;
				for (int r = 0; r < NUM_REG; r++) begin
					nb_valid_q[r] <= 1'b0;
					first_q[r]    <= '0;
					last_q[r]     <= '0;
					end_q[r]      <= '0;
				end
			end else begin
				offset_q    <= pos_inc;
				lf_count_q  <= lf_count_a;
				eq_seen_q   <= eq_seen_a;
				phase_q     <= phase_a;
				raw_cut_q   <= raw_cut_a;
				value_cut_q <= value_cut_a;
				line_any_q  <= line_any_a;
				for (int r = 0; r < NUM_REG; r++) begin
					nb_valid_q[r] <= nb_valid_a[r];
					first_q[r]    <= first_a[r];
					last_q[r]     <= last_a[r];
					end_q[r]      <= end_a[r];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			line_start_q   <= fmt_start[RG_LINE];
			line_length_q  <= fmt_len[RG_LINE];
			has_key_q      <= rec_eq;
			key_start_q    <= rec_eq ? fmt_start[RG_KEY]   : '0;
			key_length_q   <= rec_eq ? fmt_len[RG_KEY]     : '0;
			value_start_q  <= rec_eq ? fmt_start[RG_VALUE] : '0;
			value_length_q <= rec_eq ? fmt_len[RG_VALUE]   : '0;
			line_number_q  <= rec_lf;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_start   = line_start_q;
	assign line_length  = line_length_q;
	assign has_key      = has_key_q;
	assign key_start    = key_start_q;
	assign key_length   = key_length_q;
	assign value_start  = value_start_q;
	assign value_length = value_length_q;
	assign line_number  = line_number_q;

endmodule

// ===== tb/tb_key_value_line_splitter_top.sv =====
// Self-checking testbench for key_value_line_splitter_top: directed text, then random
// lines under both modes and several stall patterns, scored against a predictor.
// Depends on kvls_pkg and key_value_line_splitter_top.
module tb_key_value_line_splitter_top
	import kvls_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FIELD_W-1:0]  line_start;
		logic [FIELD_W-1:0]  line_length;
		logic                has_key;
		logic [FIELD_W-1:0]  key_start;
		logic [FIELD_W-1:0]  key_length;
		logic [FIELD_W-1:0]  value_start;
		logic [FIELD_W-1:0]  value_length;
		logic [LINE_N_W-1:0] line_number;
	} kv_record_t;

	typedef struct packed {
		logic       wr_cfg;
		logic       cfg_val;
		logic [7:0] ch;
		logic       last;
		logic       typed;
		logic       emits;
		kv_record_t rec;
	} stim_row_t;

	localparam int unsigned OFFSET_TOP = 65535;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 229;
	localparam int IDLE_PLAN [4] = '{0, 79, 0, 20};
	localparam int STALL_PLAN [4] = '{0, 0, 79, 20};
	localparam kv_record_t NO_REC = '0;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                raw_line_mode = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          text_byte = 8'h00;
	logic                last_byte = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FIELD_W-1:0]  line_start;
	logic [FIELD_W-1:0]  line_length;
	logic                has_key;
	logic [FIELD_W-1:0]  key_start;
	logic [FIELD_W-1:0]  key_length;
	logic [FIELD_W-1:0]  value_start;
	logic [FIELD_W-1:0]  value_length;
	logic [LINE_N_W-1:0] line_number;

	kv_record_t  pending_lines [$];
	logic [7:0]  line_bytes [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_ticket = 0;
	int          hold_taken = 0;
	int          hold_left = 0;

	// predictor state
	bit          raw_mode;
	int unsigned scan_pos;
	logic [31:0] lf_total;
	bit          eq_seen;
	bit          nb_ok [3];
	int unsigned nb_first [3];
	int unsigned nb_last [3];
	int unsigned reg_end [3];
	phase_t      scan_phase;
	bit          cut_line;
	bit          cut_value;
	bit          line_busy;

	// 'a' '=' 'b' LF, '#' LF, ' ' LF, "//" LF, empty LF, TAB '=' CR LF, NUL, 0xFF as last byte,
	// then raw mode: 'k' CR '=' 'v' NUL, back to normal mode for the closing LF.
	stim_row_t dir_rows [24] = '{
		'{1'b1, 1'b0, "a",      1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_EQ,    1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, "b",      1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_LF,    1'b0, 1'b1, 1'b1,
			'{16'd0, 16'd3, 1'b1, 16'd0, 16'd1, 16'd2, 16'd1, 32'd1}},
		'{1'b0, 1'b0, CH_HASH,  1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_LF,    1'b0, 1'b1, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_SPACE, 1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_LF,    1'b0, 1'b1, 1'b1,
			'{16'd7, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3}},
		'{1'b0, 1'b0, CH_SLASH, 1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_SLASH, 1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_LF,    1'b0, 1'b1, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_LF,    1'b0, 1'b1, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_TAB,   1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_EQ,    1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_CR,    1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_LF,    1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_NUL,   1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, 8'hFF,    1'b1, 1'b0, 1'b0, NO_REC},
		'{1'b1, 1'b1, "k",      1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_CR,    1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_EQ,    1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, "v",      1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b0, 1'b0, CH_NUL,   1'b0, 1'b0, 1'b0, NO_REC},
		'{1'b1, 1'b0, CH_LF,    1'b1, 1'b0, 1'b0, NO_REC}
	};

	key_value_line_splitter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.raw_line_mode(raw_line_mode),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_start   (line_start),
		.line_length  (line_length),
		.has_key      (has_key),
		.key_start    (key_start),
		.key_length   (key_length),
		.value_start  (value_start),
		.value_length (value_length),
		.line_number  (line_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned sat_next(int unsigned x);
		return (x >= OFFSET_TOP) ? OFFSET_TOP : x + 1;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_field(int unsigned x);
		return (x > FIELD_MAX) ? FIELD_MAX : x[FIELD_W-1:0];
	endfunction

	function automatic void open_line_state(int unsigned at);
		eq_seen = 1'b0;
		for (int r = 0; r < NUM_REG; r++) begin
			nb_ok[r] = 1'b0;
			nb_first[r] = 0;
			nb_last[r] = 0;
			reg_end[r] = at;
		end
		scan_phase = PH_AWAIT;
		cut_line = 1'b0;
		cut_value = 1'b0;
		line_busy = 1'b0;
	endfunction

	function automatic void restart_text();
		scan_pos = 0;
		lf_total = '0;
		open_line_state(0);
	endfunction

	function automatic void grow_region(int r, int unsigned p, logic [7:0] c);
		reg_end[r] = sat_next(p);
		if (c != CH_SPACE && c != CH_TAB) begin
			if (!nb_ok[r]) begin
				nb_ok[r] = 1'b1;
				nb_first[r] = p;
			end
			nb_last[r] = p;
		end
	endfunction

	// an all-blank region reports zero length at the offset of the byte that ended it
	function automatic void region_span(int r, output logic [FIELD_W-1:0] s,
			output logic [FIELD_W-1:0] l);
		if (nb_ok[r]) begin
			s = clamp_field(nb_first[r]);
			l = clamp_field(nb_last[r] - nb_first[r] + 1);
		end else begin
			s = clamp_field(reg_end[r]);
			l = '0;
		end
	endfunction

	function automatic bit scan_byte(logic [7:0] c, output kv_record_t rec);
		int unsigned p;
		bit emit;
		p = scan_pos;
		scan_pos = sat_next(p);
		rec = '0;
		if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
			if (c == CH_LF)
				lf_total = lf_total + 1;
			if (raw_mode && c != CH_LF) begin
				cut_line = 1'b1;
				if (eq_seen)
					cut_value = 1'b1;
				return 1'b0;
			end
			emit = raw_mode || (line_busy && scan_phase != PH_COMMENT);
			if (emit) begin
				region_span(RG_LINE, rec.line_start, rec.line_length);
				rec.has_key = eq_seen;
				if (eq_seen) begin
					region_span(RG_KEY, rec.key_start, rec.key_length);
					region_span(RG_VALUE, rec.value_start, rec.value_length);
				end
				rec.line_number = lf_total;
			end
			open_line_state(sat_next(p));
			return emit;
		end
		line_busy = 1'b1;
		case (scan_phase)
			PH_AWAIT: begin
				if (c == CH_HASH)
					scan_phase = PH_COMMENT;
				else if (c == CH_SLASH)
					scan_phase = PH_SLASH;
				else if (c != CH_SPACE && c != CH_TAB)
					scan_phase = PH_CONTENT;
			end
			PH_SLASH: scan_phase = (c == CH_SLASH) ? PH_COMMENT : PH_CONTENT;
			default: ;
		endcase
		if (!cut_line)
			grow_region(RG_LINE, p, c);
		if (c == CH_EQ && !eq_seen) begin
			eq_seen = 1'b1;
			cut_value = 1'b0;
			nb_ok[RG_VALUE] = 1'b0;
			reg_end[RG_VALUE] = sat_next(p);
		end else if (!eq_seen) begin
			if (!cut_line)
				grow_region(RG_KEY, p, c);
		end else if (!cut_value) begin
			grow_region(RG_VALUE, p, c);
		end
		return 1'b0;
	endfunction

	// a last byte other than LF implies one LF after it; then the text starts over at offset 0
	function automatic bit predict_line(logic [7:0] c, logic last, output kv_record_t rec);
		kv_record_t tail;
		bit n;
		bit m;
		n = scan_byte(c, rec);
		if (last && c != CH_LF) begin
			m = scan_byte(CH_LF, tail);
			if (m && !n) begin
				rec = tail;
				n = 1'b1;
			end
		end
		if (last)
			restart_text();
		return n;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function automatic void add_blanks();
		repeat ($urandom_range(0, 3))
			line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endfunction

	function automatic void add_word();
		int r;
		repeat ($urandom_range(0, 6)) begin
			r = $urandom_range(0, 19);
			if (r <= 11)
				line_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
			else if (r <= 13)
				line_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
			else
				case (r)
					14: line_bytes.push_back(CH_EQ);
					15: line_bytes.push_back(CH_HASH);
					16: line_bytes.push_back(CH_SLASH);
					17: line_bytes.push_back(CH_SPACE);
					18: line_bytes.push_back(CH_TAB);
					default: line_bytes.push_back(8'($urandom_range(128, 255)));
				endcase
		end
	endfunction

	task automatic drive_byte(input logic [7:0] c, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= c;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		kv_record_t rec;
		bit got;
		drive_byte(c, last);
		got = predict_line(c, last, rec);
		if (got)
			pending_lines.push_back(rec);
	endtask

	// end_mode: 0 keeps the text open, 1 ends it now and then, 2 always ends it
	task automatic send_line(input int end_mode);
		int kind;
		int term;
		bit end_text;
		line_bytes.delete();
		kind = $urandom_range(0, 15);
		if (kind <= 8) begin
			add_blanks();
			add_word();
			add_blanks();
			if ($urandom_range(0, 9) != 0)
				line_bytes.push_back(CH_EQ);
			add_blanks();
			add_word();
			add_blanks();
		end else if (kind == 9) begin
			add_blanks();
			line_bytes.push_back(CH_HASH);
			add_word();
		end else if (kind <= 11) begin
			add_blanks();
			line_bytes.push_back(CH_SLASH);
			if (kind == 10)
				line_bytes.push_back(CH_SLASH);
			add_word();
		end else if (kind == 12) begin
			add_blanks();
		end else if (kind >= 14) begin
			repeat ($urandom_range(1, 12))
				line_bytes.push_back(8'($urandom_range(0, 255)));
		end
		term = $urandom_range(0, 9);
		if (term <= 5) begin
			line_bytes.push_back(CH_LF);
		end else if (term == 6) begin
			line_bytes.push_back(CH_CR);
		end else if (term == 7) begin
			line_bytes.push_back(CH_CR);
			line_bytes.push_back(CH_LF);
		end else begin
			line_bytes.push_back(CH_NUL);
		end
		end_text = (end_mode == 2) || (end_mode == 1 && $urandom_range(0, 19) == 0);
		// a text may also stop short of its last terminator byte
		if (end_text && $urandom_range(0, 1) && line_bytes.size() > 1)
			void'(line_bytes.pop_back());
		foreach (line_bytes[j])
			send_byte(line_bytes[j], end_text && j == line_bytes.size() - 1);
	endtask

	task automatic write_mode(input logic v);
		in_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		// bytes that end no line may still be in the two-stage pipe
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		raw_line_mode <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		raw_mode = v;
	endtask

	always @(posedge clk) begin : record_check
		kv_record_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lines.size() == 0) begin
				$error("record with no line pending, line_number %0d", line_number);
				mismatches++;
			end else begin
				want = pending_lines.pop_front();
				check_field("line_start", 32'(want.line_start), 32'(line_start));
				check_field("line_length", 32'(want.line_length), 32'(line_length));
				check_field("has_key", 32'(want.has_key), 32'(has_key));
				check_field("key_start", 32'(want.key_start), 32'(key_start));
				check_field("key_length", 32'(want.key_length), 32'(key_length));
				check_field("value_start", 32'(want.value_start), 32'(value_start));
				check_field("value_length", 32'(want.value_length), 32'(value_length));
				check_field("line_number", want.line_number, line_number);
			end
		end
		// a long hold-off lets the splitter fill up and push back on the sender
		if (hold_ticket != hold_taken) begin
			hold_taken <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin : stimulus
		kv_record_t rec;
		bit got;
		int goal;
		raw_mode = 1'b0;
		restart_text();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].wr_cfg)
				write_mode(dir_rows[k].cfg_val);
			drive_byte(dir_rows[k].ch, dir_rows[k].last);
			got = predict_line(dir_rows[k].ch, dir_rows[k].last, rec);
			if (dir_rows[k].typed) begin
				if (dir_rows[k].emits)
					pending_lines.push_back(dir_rows[k].rec);
			end else if (got) begin
				pending_lines.push_back(rec);
			end
		end

		for (int p = 0; p < 4; p++) begin
			for (int m = 0; m < 2; m++) begin
				write_mode(m[0]);
				send_idle_pct <= IDLE_PLAN[p];
				stall_pct <= STALL_PLAN[p];
				if (p == 0 && m == 0)
					hold_ticket <= hold_ticket + 1;
				goal = items_sent + PHASE_ITEMS;
				while (items_sent < goal)
					send_line(1);
			end
		end

		in_valid <= 1'b0;
		while (pending_lines.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("status: fail");
		$finish;
	end

endmodule
